>>> rtl/sha1s_pkg.sv
package sha1s_pkg;

    typedef logic [31:0] t_word;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_ROUND,
        ST_UPDATE,
        ST_PAD,
        ST_LEN,
        ST_EMIT
    } t_state;

    // Commands from the sequencer to the shared round datapath
    typedef struct packed {
        logic       shift;      // shift one byte into the block
        logic [7:0] byte_val;
        logic       load_vars;  // a..e <= chaining value
        logic       round;      // run one round
        logic [6:0] round_idx;
        logic       update;     // chaining value += a..e
        logic       init_h;     // chaining value <= initial value
    } t_core_cmd;

    // Digest word hand-off to the output register
    typedef struct packed {
        logic       load;
        logic [2:0] num;
        logic       last;
    } t_emit;

    localparam t_word K_0 = 32'h5A82_7999;
    localparam t_word K_1 = 32'h6ED9_EBA1;
    localparam t_word K_2 = 32'h8F1B_BCDC;
    localparam t_word K_3 = 32'hCA62_C1D6;

    localparam t_word H_INIT_0 = 32'h6745_2301;
    localparam t_word H_INIT_1 = 32'hEFCD_AB89;
    localparam t_word H_INIT_2 = 32'h98BA_DCFE;
    localparam t_word H_INIT_3 = 32'h1032_5476;
    localparam t_word H_INIT_4 = 32'hC3D2_E1F0;

    localparam logic [7:0] PAD_BYTE = 8'h80;

    localparam logic [6:0] ROUND_CH_LAST  = 7'd19;
    localparam logic [6:0] ROUND_PA_LAST  = 7'd39;
    localparam logic [6:0] ROUND_MAJ_LAST = 7'd59;
    localparam logic [6:0] ROUND_LAST     = 7'd79;

    localparam logic [5:0] POS_LAST     = 6'd63;  // last byte of a block
    localparam logic [5:0] POS_ZERO_END = 6'd55;  // last byte before the length field
    localparam logic [2:0] LEN_LAST     = 3'd7;
    localparam logic [2:0] WORD_LAST    = 3'd4;

    localparam logic [63:0] BYTE_BITS = 64'd8;

endpackage

>>> rtl/sha1s_in_if.sv
interface sha1s_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] data_byte;
    logic       byte_present;
    logic       end_of_message;

    modport source (output valid, data_byte, byte_present, end_of_message, input ready);
    modport sink   (input valid, data_byte, byte_present, end_of_message, output ready);
endinterface

>>> rtl/sha1s_out_if.sv
interface sha1s_out_if;
    logic        valid;
    logic        ready;
    logic [31:0] digest_word;
    logic [2:0]  word_number;
    logic        last_word;

    modport source (output valid, digest_word, word_number, last_word, input ready);
    modport sink   (input valid, digest_word, word_number, last_word, output ready);
endinterface

>>> rtl/sha1s_core.sv
module sha1s_core (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  sha1s_pkg::t_core_cmd  i_cmd,
    output logic [159:0]          o_digest
);
    import sha1s_pkg::*;

    // Block as a 16-word shift line, word 0 in the top bits
    logic [511:0] r_blk;
    t_word        r_a, r_b, r_c, r_d, r_e;
    t_word        r_h0, r_h1, r_h2, r_h3, r_h4;

    t_word w_w0, w_w2, w_w8, w_w13, w_sched;
    t_word w_f, w_k, w_t;

    assign w_w0    = r_blk[511:480];
    assign w_w2    = r_blk[447:416];
    assign w_w8    = r_blk[255:224];
    assign w_w13   = r_blk[95:64];
    assign w_sched = {w_w13[30:0] ^ w_w8[30:0] ^ w_w2[30:0] ^ w_w0[30:0],
                      w_w13[31] ^ w_w8[31] ^ w_w2[31] ^ w_w0[31]};

    always_comb begin
        if (i_cmd.round_idx inside {[7'd0:ROUND_CH_LAST]}) begin
            w_f = (r_b & r_c) | (~r_b & r_d);
            w_k = K_0;
        end else if (i_cmd.round_idx inside {[7'd0:ROUND_PA_LAST]}) begin
            w_f = r_b ^ r_c ^ r_d;
            w_k = K_1;
        end else if (i_cmd.round_idx inside {[7'd0:ROUND_MAJ_LAST]}) begin
            w_f = (r_b & r_c) | (r_b & r_d) | (r_c & r_d);
            w_k = K_2;
        end else begin
            w_f = r_b ^ r_c ^ r_d;
            w_k = K_3;
        end
    end

    assign w_t = {r_a[26:0], r_a[31:27]} + w_f + r_e + w_k + w_w0;

    always_ff @(posedge i_clk) begin
        if (i_cmd.shift) begin
            r_blk <= {r_blk[503:0], i_cmd.byte_val};
        end else if (i_cmd.round) begin
            r_blk <= {r_blk[479:0], w_sched};
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load_vars) begin
            r_a <= r_h0;
            r_b <= r_h1;
            r_c <= r_h2;
            r_d <= r_h3;
            r_e <= r_h4;
        end else if (i_cmd.round) begin
            r_e <= r_d;
            r_d <= r_c;
            r_c <= {r_b[1:0], r_b[31:2]};
            r_b <= r_a;
            r_a <= w_t;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n || i_cmd.init_h) begin
            r_h0 <= H_INIT_0;
            r_h1 <= H_INIT_1;
            r_h2 <= H_INIT_2;
            r_h3 <= H_INIT_3;
            r_h4 <= H_INIT_4;
        end else if (i_cmd.update) begin
            r_h0 <= r_h0 + r_a;
            r_h1 <= r_h1 + r_b;
            r_h2 <= r_h2 + r_c;
            r_h3 <= r_h3 + r_d;
            r_h4 <= r_h4 + r_e;
        end
    end

    assign o_digest = {r_h0, r_h1, r_h2, r_h3, r_h4};

endmodule

>>> rtl/sha1s_ctrl.sv
module sha1s_ctrl (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_in_valid,
    input  logic [7:0]            i_in_byte,
    input  logic                  i_in_present,
    input  logic                  i_in_end,
    output logic                  o_in_ready,
    input  logic                  i_out_free,
    output sha1s_pkg::t_core_cmd  o_cmd,
    output sha1s_pkg::t_emit      o_emit
);
    import sha1s_pkg::*;

    t_state      r_state, n_state;
    logic [5:0]  r_pos;
    logic [63:0] r_cnt;
    logic [6:0]  r_rnd;
    logic [2:0]  r_lcnt;
    logic [2:0]  r_word;
    logic        r_final;
    logic        r_len_done;
    logic        r_pad_first;

    logic       w_acc;
    logic [7:0] w_len_byte;

    assign w_acc      = i_in_valid && (r_state == ST_IDLE);
    assign o_in_ready = (r_state == ST_IDLE);

    // Length field goes out most significant byte first
    always_comb begin
        case (r_lcnt)
            3'd0:    w_len_byte = r_cnt[63:56];
            3'd1:    w_len_byte = r_cnt[55:48];
            3'd2:    w_len_byte = r_cnt[47:40];
            3'd3:    w_len_byte = r_cnt[39:32];
            3'd4:    w_len_byte = r_cnt[31:24];
            3'd5:    w_len_byte = r_cnt[23:16];
            3'd6:    w_len_byte = r_cnt[15:8];
            default: w_len_byte = r_cnt[7:0];
        endcase
    end

    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_IDLE: begin
                if (w_acc) begin
                    if (i_in_present && r_pos == POS_LAST) begin
                        n_state = ST_ROUND;
                    end else if (i_in_end) begin
                        n_state = ST_PAD;
                    end
                end
            end
            ST_ROUND: begin
                if (r_rnd == ROUND_LAST) begin
                    n_state = ST_UPDATE;
                end
            end
            ST_UPDATE: begin
                if (!r_final) begin
                    n_state = ST_IDLE;
                end else if (r_len_done) begin
                    n_state = ST_EMIT;
                end else begin
                    n_state = ST_PAD;
                end
            end
            ST_PAD: begin
                if (r_pos == POS_LAST) begin
                    n_state = ST_ROUND;
                end else if (r_pos == POS_ZERO_END) begin
                    n_state = ST_LEN;
                end
            end
            ST_LEN: begin
                if (r_lcnt == LEN_LAST) begin
                    n_state = ST_ROUND;
                end
            end
            ST_EMIT: begin
                if (i_out_free && r_word == WORD_LAST) begin
                    n_state = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    always_comb begin
        o_cmd  = '0;
        o_emit = '0;
        o_cmd.round_idx = r_rnd;
        case (r_state)
            ST_IDLE: begin
                o_cmd.shift     = w_acc && i_in_present;
                o_cmd.byte_val  = i_in_byte;
                o_cmd.load_vars = w_acc && i_in_present && (r_pos == POS_LAST);
            end
            ST_ROUND: begin
                o_cmd.round = 1'b1;
            end
            ST_UPDATE: begin
                o_cmd.update = 1'b1;
            end
            ST_PAD: begin
                o_cmd.shift     = 1'b1;
                o_cmd.byte_val  = r_pad_first ? PAD_BYTE : 8'h00;
                o_cmd.load_vars = (r_pos == POS_LAST);
            end
            ST_LEN: begin
                o_cmd.shift     = 1'b1;
                o_cmd.byte_val  = w_len_byte;
                o_cmd.load_vars = (r_lcnt == LEN_LAST);
            end
            ST_EMIT: begin
                o_emit.load  = i_out_free;
                o_emit.num   = r_word;
                o_emit.last  = (r_word == WORD_LAST);
                o_cmd.init_h = i_out_free && (r_word == WORD_LAST);
            end
            default: begin
                o_cmd = '0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_pos       <= '0;
            r_cnt       <= '0;
            r_rnd       <= '0;
            r_lcnt      <= '0;
            r_word      <= '0;
            r_final     <= 1'b0;
            r_len_done  <= 1'b0;
            r_pad_first <= 1'b0;
        end else begin
            r_state <= n_state;
            if (o_cmd.shift) begin
                r_pos <= r_pos + 6'd1;
            end
            if (o_cmd.load_vars) begin
                r_rnd <= '0;
            end else if (o_cmd.round) begin
                r_rnd <= r_rnd + 7'd1;
            end
            if (w_acc) begin
                r_final     <= i_in_end;
                r_pad_first <= i_in_end;
                if (i_in_present) begin
                    r_cnt <= r_cnt + BYTE_BITS;
                end
            end
            if (r_state == ST_PAD) begin
                r_pad_first <= 1'b0;
                if (r_pos == POS_ZERO_END) begin
                    r_lcnt <= '0;
                end
            end
            if (r_state == ST_LEN) begin
                r_lcnt <= r_lcnt + 3'd1;
                if (r_lcnt == LEN_LAST) begin
                    r_len_done <= 1'b1;
                end
            end
            if (o_emit.load) begin
                if (o_emit.last) begin
                    r_word     <= '0;
                    r_cnt      <= '0;
                    r_final    <= 1'b0;
                    r_len_done <= 1'b0;
                end else begin
                    r_word <= r_word + 3'd1;
                end
            end
        end
    end

endmodule

>>> rtl/sha1_stream_hasher.sv
// Byte transaction without a block boundary: taken while ready stays high.
// A byte that fills a 64-byte block starts a compression (80 rounds, one update)
// on the single shared round unit; no further byte is taken until it is done.
// End of message: padding bytes one per cycle up to 56, 8 length bytes, each block
// compressed (one or two), then five digest words, one per cycle unless stalled.
// Reset (i_rst_n low, synchronous): sequencer idle, counts cleared, chaining value to IV.
module sha1_stream_hasher (
    input  logic        i_clk,
    input  logic        i_rst_n,
    sha1s_in_if.sink    i_in,
    sha1s_out_if.source o_out
);
    import sha1s_pkg::*;

    t_core_cmd     w_cmd;
    t_emit         w_emit;
    logic [159:0]  w_digest;
    logic          w_out_free;
    logic          w_in_ready;
    t_word         w_sel_word;

    logic          r_out_valid;
    t_word         r_out_word;
    logic [2:0]    r_out_num;
    logic          r_out_last;

    // The output register frees up when its transaction is taken
    assign w_out_free = !r_out_valid || o_out.ready;

    // Sequencer: byte packing, padding, length field, round count, digest walk
    sha1s_ctrl u_ctrl (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in_valid   (i_in.valid),
        .i_in_byte    (i_in.data_byte),
        .i_in_present (i_in.byte_present),
        .i_in_end     (i_in.end_of_message),
        .o_in_ready   (w_in_ready),
        .i_out_free   (w_out_free),
        .o_cmd        (w_cmd),
        .o_emit       (w_emit)
    );

    // Shared round unit with block shift line, working variables and chaining value
    sha1s_core u_core (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_cmd    (w_cmd),
        .o_digest (w_digest)
    );

    assign i_in.ready = w_in_ready;

    // Pick the digest word, most significant first
    always_comb begin
        case (w_emit.num)
            3'd0:    w_sel_word = w_digest[159:128];
            3'd1:    w_sel_word = w_digest[127:96];
            3'd2:    w_sel_word = w_digest[95:64];
            3'd3:    w_sel_word = w_digest[63:32];
            default: w_sel_word = w_digest[31:0];
        endcase
    end

    // Hold the valid flag until the transaction is taken
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_emit.load) begin
            r_out_valid <= 1'b1;
        end else if (o_out.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    // Payload needs no reset
    always_ff @(posedge i_clk) begin
        if (w_emit.load) begin
            r_out_word <= w_sel_word;
            r_out_num  <= w_emit.num;
            r_out_last <= w_emit.last;
        end
    end

    assign o_out.valid       = r_out_valid;
    assign o_out.digest_word = r_out_word;
    assign o_out.word_number = r_out_num;
    assign o_out.last_word   = r_out_last;

`ifndef NO_ASSERTIONS
    // The final word carries position four
    a_last_pos : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out.valid && o_out.last_word |-> o_out.word_number == WORD_LAST)
        else $error("last digest word not at position four");

    // A closing transaction starts padding or a block compression, so input stalls next cycle
    a_end_stalls : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in.valid && i_in.ready && i_in.end_of_message |=> !i_in.ready)
        else $error("input still ready after end of message");

    // Digest words follow back to back in order
    a_word_order : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out.valid && o_out.ready && !o_out.last_word |=>
            o_out.valid && o_out.word_number == $past(o_out.word_number) + 3'd1)
        else $error("digest words out of order");

    // No new message is taken while digest words are still to come
    a_no_accept_emit : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out.valid && !o_out.last_word |-> !i_in.ready)
        else $error("input ready during digest output");
`endif

endmodule

>>> tb/sha1s_checker.sv
`timescale 1ns / 1ps

module sha1s_checker (
    input  logic  i_clk,
    input  logic  i_rst_n,
    sha1s_in_if   i_in_mon,
    sha1s_out_if  i_out_mon,
    output int    o_fail_count,
    output int    o_pending
);
    import sha1s_pkg::*;

    typedef struct packed {
        t_word      word;
        logic [2:0] num;
        logic       last;
    } t_digest_entry;

    t_digest_entry expected_digest_q [$];

    // Hash state tracked alongside the block
    t_word       chain [5];
    t_word       msg_block [16];
    logic [63:0] msg_bits;

    function automatic t_word rotl(t_word x, int n);
        return (x << n) | (x >> (32 - n));
    endfunction

    function automatic void store_byte(int pos, logic [7:0] v);
        msg_block[pos / 4][8 * (3 - pos % 4) +: 8] = v;
    endfunction

    function automatic void restart_chain();
        chain    = '{H_INIT_0, H_INIT_1, H_INIT_2, H_INIT_3, H_INIT_4};
        msg_bits = '0;
    endfunction

    task automatic compress_block();
        t_word sched [80];
        t_word a, b, c, d, e, f, k, tmp;
        for (int r = 0; r < 16; r++) sched[r] = msg_block[r];
        for (int r = 16; r < 80; r++)
            sched[r] = rotl(sched[r-3] ^ sched[r-8] ^ sched[r-14] ^ sched[r-16], 1);
        a = chain[0];
        b = chain[1];
        c = chain[2];
        d = chain[3];
        e = chain[4];
        for (int r = 0; r < 80; r++) begin
            if (r <= ROUND_CH_LAST) begin
                f = (b & c) | (~b & d);
                k = K_0;
            end else if (r <= ROUND_PA_LAST) begin
                f = b ^ c ^ d;
                k = K_1;
            end else if (r <= ROUND_MAJ_LAST) begin
                f = (b & c) | (b & d) | (c & d);
                k = K_2;
            end else begin
                f = b ^ c ^ d;
                k = K_3;
            end
            tmp = rotl(a, 5) + f + e + k + sched[r];
            e = d;
            d = c;
            c = rotl(b, 30);
            b = a;
            a = tmp;
        end
        chain[0] += a;
        chain[1] += b;
        chain[2] += c;
        chain[3] += d;
        chain[4] += e;
    endtask

    // Absorb one input transaction; on an end mark, pad and queue the digest
    task automatic hash_item(logic [7:0] data, logic present, logic eom);
        int pos;
        t_digest_entry entry;
        if (present) begin
            pos = int'(msg_bits[8:3]);
            store_byte(pos, data);
            msg_bits += BYTE_BITS;
            if (pos == int'(POS_LAST)) compress_block();
        end
        if (eom) begin
            pos = int'(msg_bits[8:3]);
            store_byte(pos, PAD_BYTE);
            if (pos > int'(POS_ZERO_END)) begin
                // no room for the length: flush an extra block
                for (int i = pos + 1; i <= int'(POS_LAST); i++) store_byte(i, 8'h00);
                compress_block();
                for (int i = 0; i <= int'(POS_ZERO_END); i++) store_byte(i, 8'h00);
            end else begin
                for (int i = pos + 1; i <= int'(POS_ZERO_END); i++) store_byte(i, 8'h00);
            end
            msg_block[14] = msg_bits[63:32];
            msg_block[15] = msg_bits[31:0];
            compress_block();
            for (int i = 0; i <= int'(WORD_LAST); i++) begin
                entry.word = chain[i];
                entry.num  = 3'(i);
                entry.last = (i == int'(WORD_LAST));
                expected_digest_q.insert(expected_digest_q.size(), entry);
            end
            restart_chain();
        end
    endtask

    task automatic check_word();
        t_digest_entry exp_w;
        if (expected_digest_q.size() == 0) begin
            $error("digest_word: unexpected transaction, got %08h", i_out_mon.digest_word);
            o_fail_count++;
        end else begin
            exp_w = expected_digest_q.pop_front();
            if (i_out_mon.digest_word !== exp_w.word) begin
                $error("digest_word: expected %08h, got %08h", exp_w.word,
                       i_out_mon.digest_word);
                o_fail_count++;
            end
            if (i_out_mon.word_number !== exp_w.num) begin
                $error("word_number: expected %0d, got %0d", exp_w.num,
                       i_out_mon.word_number);
                o_fail_count++;
            end
            if (i_out_mon.last_word !== exp_w.last) begin
                $error("last_word: expected %0b, got %0b", exp_w.last,
                       i_out_mon.last_word);
                o_fail_count++;
            end
        end
    endtask

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            restart_chain();
            for (int i = 0; i < 16; i++) msg_block[i] = '0;
            expected_digest_q.delete();
        end else begin
            if (i_in_mon.valid && i_in_mon.ready)
                hash_item(i_in_mon.data_byte, i_in_mon.byte_present, i_in_mon.end_of_message);
            if (i_out_mon.valid && i_out_mon.ready)
                check_word();
        end
        o_pending = expected_digest_q.size();
    end

endmodule

>>> tb/tb_top.sv
`timescale 1ns / 1ps

module tb_top;

    // Give up after this many cycles without a single transaction on either side.
    // The slowest legal stretch is a message end with two blocks to compress
    // plus stalls, so this leaves a wide margin.
    localparam int STALL_LIMIT  = 5000;
    // Cycles to keep watching after the last digest word, to catch stray output
    localparam int DRAIN_CYCLES = 300;
    // Stop opening new random messages once this many meaningful items went in
    localparam int ITEM_TARGET  = 480;

    logic i_clk   = 1'b0;
    logic i_rst_n = 1'b0;

    sha1s_in_if  in_bus ();
    sha1s_out_if out_bus ();

    int fail_count;
    int pending;
    int items_sent     = 0;
    int stall_cycles   = 0;
    int send_idle_pct  = 0;
    int recv_stall_pct = 0;

    sha1_stream_hasher i_dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_bus),
        .o_out   (out_bus)
    );

    sha1s_checker u_checker (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in_mon     (in_bus),
        .i_out_mon    (out_bus),
        .o_fail_count (fail_count),
        .o_pending    (pending)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // Digest receiver: decide ready afresh at every falling edge, so that stalls
    // land on any word of the digest, including the first and the last.
    initial begin
        out_bus.ready = 1'b0;
        forever begin
            @(negedge i_clk);
            out_bus.ready <= ($urandom_range(0, 99) >= recv_stall_pct);
        end
    end

    // Watchdog: count cycles in which nothing moves on either channel
    always @(posedge i_clk) begin
        if (!i_rst_n || (in_bus.valid && in_bus.ready) || (out_bus.valid && out_bus.ready)) begin
            stall_cycles <= 0;
        end else begin
            stall_cycles <= stall_cycles + 1;
            if (stall_cycles >= STALL_LIMIT) begin
                $display("tb_top failed");
                $finish;
            end
        end
    end

    // Present one item and hold it until the block takes it. Entered just after
    // a rising edge; valid is only rewritten once per falling edge, so an item
    // that follows straight on keeps valid high without a glitch.
    task automatic send_item(logic [7:0] data, logic present, logic eom);
        @(negedge i_clk);
        while ($urandom_range(0, 99) < send_idle_pct) begin
            in_bus.valid <= 1'b0;
            @(negedge i_clk);
        end
        in_bus.valid          <= 1'b1;
        in_bus.data_byte      <= data;
        in_bus.byte_present   <= present;
        in_bus.end_of_message <= eom;
        do @(posedge i_clk); while (!in_bus.ready);
        // items with neither flag are ignored by the block, so leave them uncounted
        if (present || eom) items_sent++;
    endtask

    // One message of len bytes with random content. The end mark rides either on
    // the last byte or on a separate empty item; a few ignored items are mixed in.
    task automatic send_message(int len, bit mark_on_byte);
        for (int n = 0; n < len; n++) begin
            if ($urandom_range(0, 99) < 8) send_item(8'($urandom), 1'b0, 1'b0);
            send_item(8'($urandom), 1'b1, mark_on_byte && (n == len - 1));
        end
        if (!mark_on_byte || len == 0) send_item(8'($urandom), 1'b0, 1'b1);
    endtask

    // Mostly short messages; a good share at the padding boundaries, where
    // the 0x80 byte and the length either just fit or spill into an extra
    // block, and a few spanning two or three blocks.
    function automatic int pick_length();
        int roll;
        roll = $urandom_range(0, 99);
        if (roll < 50) return $urandom_range(0, 16);
        if (roll < 75) begin
            case ($urandom_range(0, 7))
                0:       return 0;
                1:       return 55;
                2:       return 56;
                3:       return 57;
                4:       return 63;
                5:       return 64;
                6:       return 119;
                default: return 120;
            endcase
        end
        if (roll < 90) return $urandom_range(17, 70);
        return $urandom_range(100, 140);
    endfunction

    initial begin
        int phase;
        in_bus.valid          = 1'b0;
        in_bus.data_byte      = 8'h00;
        in_bus.byte_present   = 1'b0;
        in_bus.end_of_message = 1'b0;

        // Hold reset, then release it on a falling edge
        repeat (8) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed: empty message straight after reset, with junk on the data lines
        send_item(8'hAB, 1'b0, 1'b1);
        // The classic three-byte message, end mark on the last byte
        send_item(8'h61, 1'b1, 1'b0);
        send_item(8'h62, 1'b1, 1'b0);
        send_item(8'h63, 1'b1, 1'b1);
        // Single all-ones byte carrying the end mark
        send_item(8'hFF, 1'b1, 1'b1);
        // Zero byte, an ignored item, then a byte and a separate empty end
        send_item(8'h00, 1'b1, 1'b0);
        send_item(8'hFF, 1'b0, 1'b0);
        send_item(8'h80, 1'b1, 1'b0);
        send_item(8'h00, 1'b0, 1'b1);
        // Ignored item between messages, then a lone zero byte with the end mark
        send_item(8'h5A, 1'b0, 1'b0);
        send_item(8'h00, 1'b1, 1'b1);
        // Two empty messages back to back
        send_item(8'h00, 1'b0, 1'b1);
        send_item(8'hFF, 1'b0, 1'b1);
        // The 64-bit length wrap lies far beyond any practical run and is not reached.

        // Random messages, stepping through the idling phases: none, sender idle,
        // receiver stalling, then both together.
        while (items_sent < ITEM_TARGET) begin
            phase = (items_sent * 4) / ITEM_TARGET;
            case (phase)
                0: begin
                    send_idle_pct  = 0;
                    recv_stall_pct = 0;
                end
                1: begin
                    send_idle_pct  = 68;
                    recv_stall_pct = 0;
                end
                2: begin
                    send_idle_pct  = 0;
                    recv_stall_pct = 68;
                end
                default: begin
                    send_idle_pct  = 35;
                    recv_stall_pct = 35;
                end
            endcase
            send_message(pick_length(), 1'($urandom_range(0, 1)));
        end

        // Drop valid, wait for every queued digest word, then watch a while longer
        @(negedge i_clk);
        in_bus.valid <= 1'b0;
        while (pending != 0) @(negedge i_clk);
        repeat (DRAIN_CYCLES) @(negedge i_clk);

        if (fail_count == 0 && pending == 0) begin
            $display("tb_top passed");
        end else begin
            $display("tb_top failed");
        end
        $finish;
    end

endmodule
